FILE: src/ies_pkg.sv
// Shared types and constants for the I2C EEPROM transaction sequencer.
// Holds bus command codes, command slot positions and the plan struct.
// No dependencies.
package ies_pkg;

	localparam int ADDR_W    = 16;
	localparam int DATA_W    = 8;
	localparam int DEV_W     = 7;
	localparam int SLOT_N    = 14;
	localparam int SLOT_W    = 4;

	// bus command codes
	typedef enum logic [2:0] {
		OP_START     = 3'd0,
		OP_SEND      = 3'd1,
		OP_RECV_ACK  = 3'd2,
		OP_RECV_BYTE = 3'd3,
		OP_SEND_ACK  = 3'd4,
		OP_SEND_NACK = 3'd5,
		OP_STOP      = 3'd6
	} bus_op_t;

	// fixed command slots, emitted lowest first
	localparam logic [SLOT_W-1:0] SL_PAGE_STOP = 4'd0;
	localparam logic [SLOT_W-1:0] SL_START     = 4'd1;
	localparam logic [SLOT_W-1:0] SL_DEV_WR    = 4'd2;
	localparam logic [SLOT_W-1:0] SL_ACK_DEV   = 4'd3;
	localparam logic [SLOT_W-1:0] SL_ADDR_HI   = 4'd4;
	localparam logic [SLOT_W-1:0] SL_ACK_HI    = 4'd5;
	localparam logic [SLOT_W-1:0] SL_ADDR_LO   = 4'd6;
	localparam logic [SLOT_W-1:0] SL_ACK_LO    = 4'd7;
	localparam logic [SLOT_W-1:0] SL_RSTART    = 4'd8;
	localparam logic [SLOT_W-1:0] SL_DEV_RD    = 4'd9;
	localparam logic [SLOT_W-1:0] SL_ACK_RD    = 4'd10;
	localparam logic [SLOT_W-1:0] SL_DATA      = 4'd11;
	localparam logic [SLOT_W-1:0] SL_DATA_ACK  = 4'd12;
	localparam logic [SLOT_W-1:0] SL_END_STOP  = 4'd13;

	// register index of the configuration port
	localparam logic REG_DEVICE_ADDRESS = 1'b0;
	localparam logic [DEV_W-1:0] DEV_RESET = 7'd80;

	// one word's worth of commands, handed from planner to emitter
	typedef struct packed {
		logic [SLOT_N-1:0] mask;
		logic              rd;
		logic              last;
		logic [ADDR_W-1:0] addr;
		logic [DATA_W-1:0] data;
	} plan_t;

	// control from planner to the page offset tracker
	typedef struct packed {
		logic              start;
		logic              advance;
		logic [ADDR_W-1:0] addr;
	} off_ctrl_t;

endpackage

FILE: src/ies_pgoff.sv
// Page offset tracker: keeps the next memory address modulo the page size.
// A new transfer computes the offset by reciprocal multiply; later words just count.
// Depends on ies_pkg.
module ies_pgoff #(
	parameter int PAGE_SIZE = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ies_pkg::off_ctrl_t ctrl,
	output logic              busy,
	output logic              off_zero
);
	import ies_pkg::*;

	localparam int OFF_W  = $clog2(PAGE_SIZE);
	localparam int RCP_SH = ADDR_W + OFF_W;
	localparam int PROD_W = 2 * ADDR_W + 1;
	localparam logic [OFF_W:0]    PAGE_W1 = (OFF_W+1)'(PAGE_SIZE);
	localparam logic [ADDR_W-1:0] PAGE_A  = ADDR_W'(PAGE_SIZE);
	// rounded-up reciprocal of the page size, exact for every 16-bit address
	localparam logic [ADDR_W:0] RCP_M =
		(ADDR_W+1)'(((64'd1 << RCP_SH) + 64'(PAGE_SIZE) - 64'd1) / 64'(PAGE_SIZE));

	logic [OFF_W-1:0]  off_q;
	logic [ADDR_W-1:0] div_q;
	logic [ADDR_W-1:0] quo_q;
	logic              busy_q;
	logic              ph_q;

	logic [PROD_W-1:0] prod;
	logic [ADDR_W-1:0] quo;
	logic [ADDR_W-1:0] rem;
	logic [OFF_W:0]    inc;
	logic [OFF_W-1:0]  adv_off;

	// quotient by reciprocal multiply, remainder by multiply-back next cycle
	always_comb begin
		prod = PROD_W'(div_q) * PROD_W'(RCP_M);
		quo  = ADDR_W'(prod >> RCP_SH);
		rem  = div_q - quo_q * PAGE_A;
	end

	// running offset; address wrap to zero restarts it
	always_comb begin
		inc = {1'b0, off_q} + 1'b1;
		if (ctrl.addr == '0 || inc == PAGE_W1) begin
			adv_off = '0;
		end else begin
			adv_off = inc[OFF_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			ph_q   <= 1'b0;
			off_q  <= '0;
		end else if (ctrl.start) begin
			busy_q <= 1'b1;
			ph_q   <= 1'b0;
			off_q  <= '0;
		end else if (busy_q) begin
			ph_q <= 1'b1;
			if (ph_q) begin
				off_q  <= rem[OFF_W-1:0];
				busy_q <= 1'b0;
			end
		end else if (ctrl.advance) begin
			off_q <= adv_off;
		end
	end

	// start address and quotient
	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			div_q <= ctrl.addr;
		end
		if (busy_q && !ph_q) begin
			quo_q <= quo;
		end
	end

	assign busy     = busy_q;
	assign off_zero = (off_q == '0);

endmodule

FILE: src/ies_plan.sv
// Transfer planner: holds transfer state and picks the command slots for a word.
// Drives the emitter plan and the page offset tracker.
// Depends on ies_pkg.
module ies_plan (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     take,
	input  logic                     func,
	input  logic [ies_pkg::ADDR_W-1:0] address,
	input  logic [ies_pkg::DATA_W-1:0] write_data,
	input  logic                     last_item,
	input  logic                     off_zero,
	output ies_pkg::plan_t           plan,
	output ies_pkg::off_ctrl_t       off_ctrl
);
	import ies_pkg::*;

	logic [ADDR_W-1:0] next_address_q;
	logic              open_q;
	logic              is_read_q;
	logic [ADDR_W-1:0] base;

	// slot selection for the waiting word
	always_comb begin
		plan      = '0;
		plan.data = write_data;
		plan.last = last_item;
		if (!open_q) begin
			plan.rd   = func;
			plan.addr = address;
			plan.mask[SL_ACK_LO:SL_START] = '1;
			if (func) begin
				plan.mask[SL_ACK_RD:SL_RSTART] = '1;
			end
		end else begin
			plan.rd   = is_read_q;
			plan.addr = next_address_q;
			// page boundary in a write: close page and re-address
			if (!is_read_q && off_zero) begin
				plan.mask[SL_ACK_LO:SL_PAGE_STOP] = '1;
			end
		end
		plan.mask[SL_DATA]     = 1'b1;
		plan.mask[SL_DATA_ACK] = 1'b1;
		plan.mask[SL_END_STOP] = last_item;
	end

	// address after this word
	always_comb begin
		base             = open_q ? next_address_q : address;
		off_ctrl.addr    = base + 1'b1;
		off_ctrl.start   = take && !open_q;
		off_ctrl.advance = take && open_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_address_q <= '0;
			open_q         <= 1'b0;
			is_read_q      <= 1'b0;
		end else if (take) begin
			next_address_q <= off_ctrl.addr;
			open_q         <= !last_item;
			if (!open_q) begin
				is_read_q <= func;
			end
		end
	end

endmodule

FILE: src/ies_emit.sv
// Command emitter: walks the slot mask into the output register one command
// per cycle while the output is not stalled. Depends on ies_pkg.
module ies_emit (
	input  logic                    clk,
	input  logic                    arst_n,
	input  ies_pkg::plan_t          plan,
	input  logic                    plan_valid,
	output logic                    plan_ready,
	input  logic [ies_pkg::DEV_W-1:0] dev,
	output logic                    m_tvalid,
	input  logic                    m_tready,
	output logic [2:0]              m_tuser,
	output logic [7:0]              m_tdata,
	output logic                    m_tlast
);
	import ies_pkg::*;

	logic [SLOT_N-1:0] mask_q;
	logic              rd_q;
	logic              last_q;
	logic [ADDR_W-1:0] addr_q;
	logic [DATA_W-1:0] data_q;

	logic              m_tvalid_q;
	bus_op_t           op_q;
	logic [7:0]        byte_q;
	logic              tlast_q;

	logic [SLOT_N-1:0] lowbit, rest;
	logic [SLOT_W-1:0] idx;
	logic              busy, fire, take;
	bus_op_t           op_d;
	logic [7:0]        byte_d;

	// lowest pending slot
	always_comb begin
		lowbit = mask_q & (~mask_q + 1'b1);
		rest   = mask_q & ~lowbit;
		idx    = '0;
		for (int i = 0; i < SLOT_N; i++) begin
			if (lowbit[i]) begin
				idx = idx | SLOT_W'(i);
			end
		end
	end

	assign busy       = |mask_q;
	assign fire       = busy && (!m_tvalid_q || m_tready);
	assign plan_ready = !busy || (fire && rest == '0);
	assign take       = plan_valid && plan_ready;

	// command for the current slot
	always_comb begin
		op_d   = OP_RECV_ACK;
		byte_d = '0;
		case (idx)
			SL_PAGE_STOP, SL_END_STOP: op_d = OP_STOP;
			SL_START, SL_RSTART:       op_d = OP_START;
			SL_DEV_WR: begin
				op_d   = OP_SEND;
				byte_d = {dev, 1'b0};
			end
			SL_DEV_RD: begin
				op_d   = OP_SEND;
				byte_d = {dev, 1'b1};
			end
			SL_ADDR_HI: begin
				op_d   = OP_SEND;
				byte_d = addr_q[ADDR_W-1:8];
			end
			SL_ADDR_LO: begin
				op_d   = OP_SEND;
				byte_d = addr_q[7:0];
			end
			SL_DATA: begin
				if (rd_q) begin
					op_d = OP_RECV_BYTE;
				end else begin
					op_d   = OP_SEND;
					byte_d = data_q;
				end
			end
			SL_DATA_ACK: begin
				if (!rd_q) begin
					op_d = OP_RECV_ACK;
				end else if (last_q) begin
					op_d = OP_SEND_NACK;
				end else begin
					op_d = OP_SEND_ACK;
				end
			end
			default: op_d = OP_RECV_ACK;
		endcase
	end

	// slot mask and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (take) begin
				mask_q <= plan.mask;
			end else if (fire) begin
				mask_q <= rest;
			end
			if (fire) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// word context and output payload
	always_ff @(posedge clk) begin
		if (take) begin
			rd_q   <= plan.rd;
			last_q <= plan.last;
			addr_q <= plan.addr;
			data_q <= plan.data;
		end
		if (fire) begin
			op_q    <= op_d;
			byte_q  <= byte_d;
			tlast_q <= (rest == '0);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = op_q;
	assign m_tdata  = byte_q;
	assign m_tlast  = tlast_q;

endmodule

FILE: src/i2c_eeprom_transaction_sequencer.sv
// Top level of the I2C EEPROM transaction sequencer.
// Instantiates ies_plan, ies_pgoff and ies_emit; depends on ies_pkg.
//
// Usage:
//   Slave stream: one word per data byte of an EEPROM transfer. tuser is the
//   transfer kind (0 write, 1 read, taken when a transfer opens), tdata holds
//   the start address and write byte, tlast closes the transfer with stop.
//   Master stream: one word per bus command (start, send byte, ack, ...),
//   tuser the command code, tdata the byte to send, tlast on the final
//   command of each input word. APB register 0 holds the 7-bit device address.
// Timing:
//   An accepted word sits in the input register until the emitter takes its
//   plan; its commands then pass one at a time into the output register.
//   Commands leave at one per cycle while the master accepts them; a word has
//   2 in mid-transfer, 3 on a final write or read byte, 9 to 13 when
//   a header goes out. The next word is planned in the same cycle as the last
//   command of the previous one, so back-to-back words keep the output busy.
//   The first word of a transfer also starts the page-offset calculation,
//   always hidden behind its 9 or more header commands.
// Reset clears transfer state; the device address returns to 0x50. When the
// master side stalls, the output word holds and the input register fills.
module i2c_eeprom_transaction_sequencer #(
	parameter int PAGE_SIZE = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	// slave stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // [15:0] address, [23:16] write_data
	input  logic        s_tuser,   // [0] func
	input  logic        s_tlast,
	// master stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] bus_byte
	output logic [2:0]  m_tuser,   // [2:0] bus_op
	output logic        m_tlast,
	// register port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import ies_pkg::*;

	logic [DEV_W-1:0]  dev_q;
	logic              in_vld_s1;
	logic              func_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic [DATA_W-1:0] data_s1;
	logic              last_s1;

	plan_t     plan;
	off_ctrl_t off_ctrl;
	logic      off_busy, off_zero;
	logic      plan_valid, plan_ready, take;

	// register port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_DEVICE_ADDRESS) ? {25'd0, dev_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_q <= DEV_RESET;
		end else if (psel && penable && pwrite && paddr[2] == REG_DEVICE_ADDRESS) begin
			dev_q <= pwdata[DEV_W-1:0];
		end
	end

	// input register
	assign plan_valid = in_vld_s1 && !off_busy;
	assign take       = plan_valid && plan_ready;
	assign s_tready   = !in_vld_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_vld_s1 <= 1'b0;
		end else if (s_tready) begin
			in_vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			func_s1 <= s_tuser;
			addr_s1 <= s_tdata[15:0];
			data_s1 <= s_tdata[23:16];
			last_s1 <= s_tlast;
		end
	end

	ies_plan u_plan (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.func       (func_s1),
		.address    (addr_s1),
		.write_data (data_s1),
		.last_item  (last_s1),
		.off_zero   (off_zero),
		.plan       (plan),
		.off_ctrl   (off_ctrl)
	);

	ies_pgoff #(
		.PAGE_SIZE (PAGE_SIZE)
	) u_pgoff (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (off_ctrl),
		.busy     (off_busy),
		.off_zero (off_zero)
	);

	ies_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.plan       (plan),
		.plan_valid (plan_valid),
		.plan_ready (plan_ready),
		.dev        (dev_q),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tuser    (m_tuser),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast)
	);

endmodule

FILE: tb/sv/i2c_eeprom_transaction_sequencer_tb.sv
`timescale 1ns / 100ps
// Testbench for the I2C EEPROM transaction sequencer: directed and random transfers in,
// predicted bus commands checked word by word on the master stream.
// Depends on ies_pkg and the i2c_eeprom_transaction_sequencer RTL.
module i2c_eeprom_transaction_sequencer_tb;
	import ies_pkg::*;

	localparam int PAGE         = 64;
	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 20;
	localparam int HOLD_CYCLES  = 300;

	// one input word: fields of a transfer byte
	typedef struct {
		logic              func;
		logic [ADDR_W-1:0] addr;
		logic [DATA_W-1:0] wdata;
		logic              last;
	} xfer_word_t;

	// one bus command as seen on the master stream
	typedef struct {
		bus_op_t           op;
		logic [DATA_W-1:0] data;
		logic              last;
	} bus_cmd_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata  = '0;
	logic        s_tuser  = 1'b0;
	logic        s_tlast  = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic [2:0]  m_tuser;
	logic        m_tlast;
	logic        psel     = 1'b0;
	logic        penable  = 1'b0;
	logic        pwrite   = 1'b0;
	logic [2:0]  paddr    = '0;
	logic [31:0] pwdata   = '0;
	logic [31:0] prdata;
	logic        pready;

	// sequencer model state
	logic [DEV_W-1:0]  model_dev;
	logic [ADDR_W-1:0] model_next;
	logic              model_open;
	logic              model_rd;
	bus_cmd_t          item_cmds[$];
	bus_cmd_t          pending_cmds[$];

	int err_count     = 0;
	int rx_hold_cycles = 0;
	bit tx_gaps_on    = 1'b1;

	i2c_eeprom_transaction_sequencer #(.PAGE_SIZE(PAGE)) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.s_tlast (s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic xfer_word_t mk_word(input logic func, input logic [ADDR_W-1:0] addr,
			input logic [DATA_W-1:0] wdata, input logic last);
		xfer_word_t w;
		w.func  = func;
		w.addr  = addr;
		w.wdata = wdata;
		w.last  = last;
		return w;
	endfunction

	function automatic void push_cmd(input bus_op_t op, input logic [DATA_W-1:0] b);
		bus_cmd_t c;
		c.op   = op;
		c.data = b;
		c.last = 1'b0;
		item_cmds.push_back(c);
	endfunction

	// start, device write address, two address bytes, each acked
	function automatic void push_header(input logic [ADDR_W-1:0] addr);
		push_cmd(OP_START, 8'h00);
		push_cmd(OP_SEND, {model_dev, 1'b0});
		push_cmd(OP_RECV_ACK, 8'h00);
		push_cmd(OP_SEND, addr[15:8]);
		push_cmd(OP_RECV_ACK, 8'h00);
		push_cmd(OP_SEND, addr[7:0]);
		push_cmd(OP_RECV_ACK, 8'h00);
	endfunction

	// work out the bus commands one accepted word causes
	function automatic void predict_commands(input xfer_word_t w);
		bus_cmd_t c;
		item_cmds.delete();
		if (!model_open) begin
			model_open = 1'b1;
			model_rd   = w.func;
			model_next = w.addr;
			push_header(model_next);
			if (model_rd) begin
				push_cmd(OP_START, 8'h00);
				push_cmd(OP_SEND, {model_dev, 1'b1});
				push_cmd(OP_RECV_ACK, 8'h00);
			end
		end else if (!model_rd && (model_next % PAGE) == 0) begin
			// page boundary inside a write: close the page, reopen at new address
			push_cmd(OP_STOP, 8'h00);
			push_header(model_next);
		end
		if (model_rd) begin
			push_cmd(OP_RECV_BYTE, 8'h00);
			push_cmd(w.last ? OP_SEND_NACK : OP_SEND_ACK, 8'h00);
		end else begin
			push_cmd(OP_SEND, w.wdata);
			push_cmd(OP_RECV_ACK, 8'h00);
		end
		model_next = model_next + 16'd1;
		if (w.last) begin
			push_cmd(OP_STOP, 8'h00);
			model_open = 1'b0;
		end
		foreach (item_cmds[i]) begin
			c      = item_cmds[i];
			c.last = (i == item_cmds.size() - 1);
			pending_cmds.push_back(c);
		end
	endfunction

	// sender gap: mostly none or short, a few long
	function automatic int pick_gap();
		int r;
		if (!tx_gaps_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// offer one word and wait for the handshake
	task automatic send_word(input xfer_word_t w);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= w.func;
		s_tdata  <= {w.wdata, w.addr};
		s_tlast  <= w.last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predict_commands(w);
	endtask

	// sender stops until every predicted command has come out
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_cmds.size() != 0);
	endtask

	// APB write of the device address register; block must be idle
	task automatic write_device_address(input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= 3'(4 * REG_DEVICE_ADDRESS);
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		model_dev = value[DEV_W-1:0];
	endtask

	// whole transfer: first word opens it, later words carry ignored func and address
	task automatic send_transfer(input logic func, input logic [ADDR_W-1:0] addr, input int len);
		for (int i = 0; i < len; i++) begin
			if (i == 0)
				send_word(mk_word(func, addr, 8'($urandom), len == 1));
			else
				send_word(mk_word(1'($urandom), 16'($urandom), 8'($urandom), i == len - 1));
		end
	endtask

	task automatic test_single_write();
		send_word(mk_word(1'b0, 16'h0000, 8'h00, 1'b1));
		send_word(mk_word(1'b0, 16'hFFFF, 8'hFF, 1'b1));
	endtask

	task automatic test_page_split_write();
		send_word(mk_word(1'b0, 16'h003E, 8'hFF, 1'b0));
		send_word(mk_word(1'b1, 16'hFFFF, 8'h00, 1'b0));
		send_word(mk_word(1'b1, 16'h1234, 8'hA5, 1'b0));
		send_word(mk_word(1'b0, 16'h0000, 8'h5A, 1'b1));
	endtask

	task automatic test_boundary_and_wrap();
		// boundary reached on the closing byte: its stop also ends the page
		send_word(mk_word(1'b0, 16'h007E, 8'h81, 1'b0));
		send_word(mk_word(1'b0, 16'h0000, 8'h7E, 1'b1));
		// address wraps to zero, which is a page boundary
		send_transfer(1'b0, 16'hFFFE, 4);
	endtask

	task automatic test_reads();
		wait_drained();
		write_device_address(32'hFFFF_FFFF);
		send_word(mk_word(1'b1, 16'hFFFF, 8'hFF, 1'b1));
		send_word(mk_word(1'b1, 16'h003E, 8'h00, 1'b0));
		send_word(mk_word(1'b0, 16'h0040, 8'hFF, 1'b0));
		send_word(mk_word(1'b0, 16'hFFFF, 8'h00, 1'b0));
		send_word(mk_word(1'b1, 16'h0000, 8'h00, 1'b1));
		wait_drained();
		write_device_address(32'h0000_0000);
		send_transfer(1'b1, 16'h0000, 2);
		send_transfer(1'b0, 16'h8000, 1);
		wait_drained();
		write_device_address({25'h0, DEV_RESET});
	endtask

	// receiver holds off while the sender keeps offering, then sender drains
	task automatic test_back_pressure();
		wait_drained();
		rx_hold_cycles = HOLD_CYCLES;
		tx_gaps_on     = 1'b0;
		send_transfer(1'b0, 16'h0010, 12);
		send_transfer(1'b1, 16'h2030, 6);
		tx_gaps_on = 1'b1;
		wait_drained();
	endtask

	task automatic test_random();
		int sent;
		int len;
		int r;
		logic [ADDR_W-1:0] addr;
		for (int phase = 0; phase < 4; phase++) begin
			wait_drained();
			case (phase)
				0: write_device_address({25'($urandom_range(0, 33554431)), 7'h00});
				1: write_device_address({25'($urandom_range(0, 33554431)), 7'h7F});
				default: write_device_address($urandom);
			endcase
			sent = 0;
			while (sent < 15) begin
				r = $urandom_range(0, 99);
				if (r < 40)
					addr = (16'($urandom) & 16'hFFC0) | 16'(PAGE - $urandom_range(1, 4));
				else if (r < 50)
					addr = 16'hFFFF - 16'($urandom_range(0, 3));
				else
					addr = 16'($urandom);
				len = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 6) : $urandom_range(7, 20);
				tx_gaps_on = ($urandom_range(0, 3) != 0);
				send_transfer(1'($urandom), addr, len);
				sent += len;
			end
		end
		tx_gaps_on = 1'b1;
	endtask

	// receiver: ready rate changes in stretches, with occasional long stalls
	initial begin : rx_ready
		int pct;
		int span;
		pct  = 100;
		span = 0;
		forever begin
			@(posedge clk);
			if (span == 0) begin
				span = $urandom_range(20, 80);
				case ($urandom_range(0, 3))
					0: pct = 100;
					1: pct = 75;
					2: pct = 40;
					default: pct = 90;
				endcase
			end
			span--;
			if (rx_hold_cycles == 0 && $urandom_range(0, 199) == 0)
				rx_hold_cycles = $urandom_range(15, 40);
			if (rx_hold_cycles > 0) begin
				m_tready <= 1'b0;
				rx_hold_cycles--;
			end else begin
				m_tready <= ($urandom_range(0, 99) < pct);
			end
		end
	end

	// compare each command word with the oldest prediction
	always @(posedge clk) begin : check_cmds
		bus_cmd_t exp_cmd;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_cmds.size() == 0) begin
				$error("unexpected command: bus_op %0d bus_byte 0x%02h", m_tuser, m_tdata);
				err_count++;
			end else begin
				exp_cmd = pending_cmds.pop_front();
				if (m_tuser !== exp_cmd.op) begin
					$error("bus_op: expected %0d, got %0d", exp_cmd.op, m_tuser);
					err_count++;
				end
				if (m_tdata !== exp_cmd.data) begin
					$error("bus_byte: expected 0x%02h, got 0x%02h", exp_cmd.data, m_tdata);
					err_count++;
				end
				if (m_tlast !== exp_cmd.last) begin
					$error("last_command: expected %0b, got %0b", exp_cmd.last, m_tlast);
					err_count++;
				end
			end
		end
	end

	// stop the run if no word moves on either side for too long
	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle = 0;
			else
				idle++;
		end
		$display("i2c_eeprom_transaction_sequencer test failed");
		$finish;
	end

	initial begin : main_seq
		model_dev  = DEV_RESET;
		model_next = '0;
		model_open = 1'b0;
		model_rd   = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_single_write();
		test_page_split_write();
		test_boundary_and_wrap();
		test_reads();
		test_back_pressure();
		test_random();
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_count == 0 && pending_cmds.size() == 0)
			$display("i2c_eeprom_transaction_sequencer test passed");
		else
			$display("i2c_eeprom_transaction_sequencer test failed");
		$finish;
	end

endmodule
